>>> hdl/assert_macros.svh
// assertion helpers shared by the quantizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// generic clocked property, off while reset is low
`define BCQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication, off while reset is low
`define BCQ_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

`else

`define BCQ_ASSERT(label, clk, rst_n, prop, msg)
`define BCQ_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg)

`endif

`endif

>>> hdl/bcq_pkg.sv
package bcq_pkg;

  localparam int COEFF_WIDTH    = 16;
  localparam int VALUE_WIDTH    = 23;
  localparam int POS_WIDTH      = 6;
  localparam int TABLE_SIZE     = 64;
  localparam int Q_WIDTH        = 7;
  localparam int D_WIDTH        = Q_WIDTH + 1;
  // magnitude of 2x+q always stays below 2^(COEFF_WIDTH+1)
  localparam int MAG_WIDTH      = COEFF_WIDTH + 1;
  localparam int RECIP_SHIFT    = MAG_WIDTH;
  localparam int PROD_WIDTH     = 2 * MAG_WIDTH;
  localparam int NUM_STAGES     = 5;
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 32;

  // standard luminance quantization table, raster order
  localparam logic [Q_WIDTH-1:0] LUMA_Q [TABLE_SIZE] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24,  7'd40,  7'd51,  7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26,  7'd58,  7'd60,  7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40,  7'd57,  7'd69,  7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51,  7'd87,  7'd80,  7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68,  7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81,  7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  typedef enum logic {
    DIR_QUANT   = 1'b0,
    DIR_DEQUANT = 1'b1
  } dir_t;

  // per-stage load enables and valid flags, index 0 is the first stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } stage_ctl_t;

endpackage

>>> hdl/bcq_datapath.sv
`include "assert_macros.svh"

module bcq_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bcq_pkg::stage_ctl_t                     ctl,
  input  bcq_pkg::dir_t                           mode,
  input  logic signed [bcq_pkg::COEFF_WIDTH-1:0]  coefficient,
  input  logic [bcq_pkg::POS_WIDTH-1:0]           position,
  output logic signed [bcq_pkg::VALUE_WIDTH-1:0]  value
);
  import bcq_pkg::*;

  // reciprocal table: floor(2^RECIP_SHIFT / (2q)), gives the quotient or one less
  logic [MAG_WIDTH-1:0] recip_tab [TABLE_SIZE];

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_recip
    localparam int unsigned RecipVal = (1 << RECIP_SHIFT) / (2 * LUMA_Q[i]);
    assign recip_tab[i] = MAG_WIDTH'(RecipVal);
  end

  // stage 1: table lookup, rounding offset, sign split
  logic [Q_WIDTH-1:0]       q;
  logic [D_WIDTH-1:0]       d;
  logic signed [MAG_WIDTH:0] n;
  logic [MAG_WIDTH:0]       n_abs;
  logic                     n_neg;
  logic                     x_neg;
  logic [COEFF_WIDTH-1:0]   x_mag;
  logic [MAG_WIDTH-1:0]     a_nxt;
  logic [MAG_WIDTH-1:0]     b_nxt;

  always_comb begin
    q     = LUMA_Q[position];
    d     = {q, 1'b0};
    n     = $signed({coefficient[COEFF_WIDTH-1], coefficient, 1'b0})
            + $signed({{(MAG_WIDTH + 1 - Q_WIDTH){1'b0}}, q});
    n_neg = n[MAG_WIDTH];
    n_abs = n_neg ? (~n + 1'b1) : n;
    x_neg = coefficient[COEFF_WIDTH-1];
    x_mag = x_neg ? (~coefficient + 1'b1) : coefficient;
    if (mode == DIR_DEQUANT) begin
      a_nxt = MAG_WIDTH'(x_mag);
      b_nxt = MAG_WIDTH'(q);
    end else begin
      a_nxt = n_abs[MAG_WIDTH-1:0];
      b_nxt = recip_tab[position];
    end
  end

  dir_t                 s1_mode_r;
  logic                 s1_neg_r;
  logic [MAG_WIDTH-1:0] s1_a_r;
  logic [MAG_WIDTH-1:0] s1_b_r;
  logic [D_WIDTH-1:0]   s1_d_r;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_mode_r <= mode;
      s1_neg_r  <= (mode == DIR_DEQUANT) ? x_neg : n_neg;
      s1_a_r    <= a_nxt;
      s1_b_r    <= b_nxt;
      s1_d_r    <= d;
    end
  end

  // stage 2: shared multiplier, reciprocal estimate or the plain product
  dir_t                  s2_mode_r;
  logic                  s2_neg_r;
  logic [MAG_WIDTH-1:0]  s2_a_r;
  logic [D_WIDTH-1:0]    s2_d_r;
  logic [PROD_WIDTH-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_mode_r <= s1_mode_r;
      s2_neg_r  <= s1_neg_r;
      s2_a_r    <= s1_a_r;
      s2_d_r    <= s1_d_r;
      s2_prod_r <= s1_a_r * s1_b_r;
    end
  end

  // stage 3: back-multiply the estimate by the divisor
  logic [MAG_WIDTH-1:0]         qe;
  logic [MAG_WIDTH+D_WIDTH-1:0] qd_full;

  always_comb begin
    qe      = s2_prod_r[RECIP_SHIFT +: MAG_WIDTH];
    qd_full = qe * s2_d_r;
  end

  dir_t                   s3_mode_r;
  logic                   s3_neg_r;
  logic [MAG_WIDTH-1:0]   s3_a_r;
  logic [D_WIDTH-1:0]     s3_d_r;
  logic [MAG_WIDTH-1:0]   s3_qe_r;
  logic [MAG_WIDTH-1:0]   s3_qd_r;
  logic [VALUE_WIDTH-1:0] s3_low_r;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_mode_r <= s2_mode_r;
      s3_neg_r  <= s2_neg_r;
      s3_a_r    <= s2_a_r;
      s3_d_r    <= s2_d_r;
      s3_qe_r   <= qe;
      // the product never exceeds the dividend, so the low bits are exact
      s3_qd_r   <= qd_full[MAG_WIDTH-1:0];
      s3_low_r  <= s2_prod_r[VALUE_WIDTH-1:0];
    end
  end

  // stage 4: remainder check, bump the estimate by one when needed
  logic [MAG_WIDTH-1:0]   rem;
  logic [MAG_WIDTH-1:0]   quot;
  logic [VALUE_WIDTH-1:0] mag_nxt;

  always_comb begin
    rem  = s3_a_r - s3_qd_r;
    quot = s3_qe_r + MAG_WIDTH'(rem >= MAG_WIDTH'(s3_d_r));
    mag_nxt = (s3_mode_r == DIR_DEQUANT) ? s3_low_r : VALUE_WIDTH'(quot);
  end

  logic                   s4_neg_r;
  logic [VALUE_WIDTH-1:0] s4_mag_r;

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_neg_r <= s3_neg_r;
      s4_mag_r <= mag_nxt;
    end
  end

  // stage 5: restore the sign, wraps to the result width
  logic [VALUE_WIDTH-1:0] s5_value_r;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_value_r <= s4_neg_r ? (~s4_mag_r + 1'b1) : s4_mag_r;
    end
  end

  assign value = $signed(s5_value_r);

  `BCQ_ASSERT_IMPLIES(a_est_not_over, clk, rst_n, ctl.valid[2] && s3_mode_r == DIR_QUANT, s3_qd_r <= s3_a_r, "quotient estimate overshoots")
  `BCQ_ASSERT_IMPLIES(a_est_one_low, clk, rst_n, ctl.valid[2] && s3_mode_r == DIR_QUANT, rem < MAG_WIDTH'({s3_d_r, 1'b0}), "quotient estimate low by more than one")

endmodule

>>> hdl/block_coefficient_quantizer_unit.sv
// jpeg luminance coefficient quantizer / dequantizer
// input channel: in_valid/in_ready transfer one signed coefficient and its raster
//   position 0..63 within the 8x8 block; the position picks the table entry q
// output channel: out_valid/out_ready transfer one result per input, in order
// mode register (apb, bit 0; reads back at byte address 0, any address writes it): 0 quantize, result is
//   (2x+q)/(2q) truncated toward zero; 1 dequantize, result is x*q
// write the mode only while no transfer is in flight
// an accepted input moves through the five register stages below in order, and
//   its result is presented from the last one
// throughput: one transfer per cycle while out_ready holds; five register stages
//   (lookup, multiply, back-multiply, remainder fix, sign) each take a new item every cycle
// division uses a reciprocal table and one correction step, no iteration
// when the receiver stalls, the stages fill up one by one and in_ready drops
//   only once every stage holds an item; nothing is dropped or repeated
// reset (rst_n low, synchronous) empties the pipeline and sets quantize mode
`include "assert_macros.svh"

module block_coefficient_quantizer_unit (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [bcq_pkg::COEFF_WIDTH-1:0]     in_coefficient,
  input  logic [bcq_pkg::POS_WIDTH-1:0]              in_position,
  // result channel
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [bcq_pkg::VALUE_WIDTH-1:0]     out_value,
  // configuration port
  input  logic                                       cfg_psel,
  input  logic                                       cfg_penable,
  input  logic                                       cfg_pwrite,
  input  logic [bcq_pkg::CFG_ADDR_WIDTH-1:0]         cfg_paddr,
  input  logic [bcq_pkg::CFG_DATA_WIDTH-1:0]         cfg_pwdata,
  output logic [bcq_pkg::CFG_DATA_WIDTH-1:0]         cfg_prdata,
  output logic                                       cfg_pready
);
  import bcq_pkg::*;

  // mode register, the only register in the map
  dir_t dir_r;
  dir_t dir_nxt;
  logic cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dir_nxt    = cfg_write ? dir_t'(cfg_pwdata[0]) : dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_QUANT;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // only the aligned word reads back the mode
  assign cfg_prdata = (cfg_paddr == '0) ? CFG_DATA_WIDTH'(dir_r) : '0;

  // pipeline flow control: a stage loads when it is empty or its item moves on
  stage_ctl_t            ctl;
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_r[k] || load[k+1];
    end
    valid_nxt[0] = load[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = load[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.load  = load;
  assign ctl.valid = valid_r;
  assign in_ready  = load[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  // arithmetic stages
  bcq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .mode        (dir_r),
    .coefficient (in_coefficient),
    .position    (in_position),
    .value       (out_value)
  );

  // backpressure only ever starts at a stalled output
  `BCQ_ASSERT_IMPLIES(a_stall_source, clk, rst_n, !in_ready, valid_r == '1 && !out_ready, "input stalled while a stage is free")
  // an accepted transfer always lands in the first stage
  `BCQ_ASSERT(a_accept_lands, clk, rst_n, in_valid && in_ready |=> valid_r[0], "accepted item missing from first stage")
  // outside reset, mode changes only through a register write
  `BCQ_ASSERT(a_mode_hold, clk, rst_n, rst_n && !cfg_write |=> $stable(dir_r), "mode changed without a write")

endmodule
